// ===== src/tacf_pkg.sv =====
// ----------------------------------------------------------------------------
// tacf_pkg: shared types and constants of the two-axis complementary filter
// Holds the item structs, the configuration bundle, the sequencer state and
// the step codes that the sequencer and the lanes agree on.
// ----------------------------------------------------------------------------
package tacf_pkg;

  // Field widths of the item payloads and of the configuration registers.
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int STATE_WIDTH_DEF = 32;

  // Coefficient operand of the lane multiplier: room for 1.0 in Q0.16, signed.
  localparam int MULB_WIDTH = COEF_WIDTH + 2;
  localparam logic [COEF_WIDTH:0] BLEND_UNITY = 17'h10000;

  // Fixed-point alignments between the formats.
  localparam int GYRO_DT_SHIFT = 4;
  localparam int ACCEL_SHIFT = 9;
  localparam int GAIN_SHIFT = 12;
  localparam int DT_SHIFT = 16;
  localparam int GYRO_SHIFT = 12;
  localparam int OUT_SHIFT = 9;

  // Register reset values.
  localparam logic [COEF_WIDTH-1:0] BLEND_RESET = 16'd65405;
  localparam logic [COEF_WIDTH-1:0] PERIOD_RESET = 16'd328;
  localparam logic [COEF_WIDTH-1:0] GAIN_RESET = 16'd2048;

  // Register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BLEND = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN = 2'd2;

  typedef struct packed {
    logic                           mode;
    logic signed [SAMPLE_WIDTH-1:0] gyro_rate_x;
    logic signed [SAMPLE_WIDTH-1:0] gyro_rate_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_angle_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_angle_y;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] angle_x;
    logic signed [SAMPLE_WIDTH-1:0] angle_y;
  } result_t;

  typedef struct packed {
    logic [COEF_WIDTH-1:0] blend;
    logic [COEF_WIDTH-1:0] period;
    logic [COEF_WIDTH-1:0] gain;
  } cfg_t;

  // Step codes of the lane micro-sequence.
  typedef logic [3:0] step_t;

  // First-order filter.
  localparam step_t F1_MUL_GYRO = 4'd0;
  localparam step_t F1_MUL_ACCEL = 4'd1;
  localparam step_t F1_MUL_BLEND = 4'd2;
  localparam step_t F1_BLEND = 4'd3;

  // Second-order filter.
  localparam step_t F2_ERROR = 4'd0;
  localparam step_t F2_MUL_EK = 4'd1;
  localparam step_t F2_EK = 4'd2;
  localparam step_t F2_MUL_EKK = 4'd3;
  localparam step_t F2_EKK = 4'd4;
  localparam step_t F2_MUL_INTEG = 4'd5;
  localparam step_t F2_INTEG = 4'd6;
  localparam step_t F2_RATE_A = 4'd7;
  localparam step_t F2_RATE_B = 4'd8;
  localparam step_t F2_MUL_ANGLE = 4'd9;
  localparam step_t F2_ANGLE = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } seq_state_t;

  // Control from the sequencer to both lanes.
  typedef struct packed {
    logic  run;
    logic  second;
    step_t step;
  } lane_ctrl_t;

endpackage

// ===== src/tacf_lane.sv =====
// ----------------------------------------------------------------------------
// tacf_lane: filter core for one axis
// Holds the angle and rate integrator of one axis and steps through the
// first- or second-order update with a single registered multiplier.
// ----------------------------------------------------------------------------
module tacf_lane #(
  parameter int STATE_WIDTH = tacf_pkg::STATE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  tacf_pkg::lane_ctrl_t                     ctrl,
  input  tacf_pkg::cfg_t                           cfg,
  input  logic signed [tacf_pkg::SAMPLE_WIDTH-1:0] gyro,
  input  logic signed [tacf_pkg::SAMPLE_WIDTH-1:0] accel,
  output logic signed [STATE_WIDTH-1:0]            angle
);

  localparam int SW = tacf_pkg::SAMPLE_WIDTH;
  localparam int MBW = tacf_pkg::MULB_WIDTH;
  localparam int PW = STATE_WIDTH + MBW;
  localparam int XW = STATE_WIDTH + MBW + 2;
  localparam logic signed [XW-1:0] X_ONE = XW'(1);
  localparam logic signed [XW-1:0] ST_MAX_X =
    {{(XW - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
  localparam logic signed [XW-1:0] ST_MIN_X = ~ST_MAX_X;

  logic signed [STATE_WIDTH-1:0] integ;
  logic signed [STATE_WIDTH-1:0] tmp;
  logic signed [STATE_WIDTH-1:0] ek;
  logic signed [PW-1:0]          prod;
  logic signed [XW-1:0]          accum;

  logic signed [STATE_WIDTH-1:0] angle_next;
  logic signed [STATE_WIDTH-1:0] integ_next;
  logic signed [STATE_WIDTH-1:0] tmp_next;
  logic signed [STATE_WIDTH-1:0] ek_next;
  logic signed [XW-1:0]          accum_next;

  logic signed [STATE_WIDTH-1:0] mul_a;
  logic signed [MBW-1:0]         mul_b;
  logic [tacf_pkg::COEF_WIDTH:0] blend_rest;

  logic signed [XW-1:0] prod_x;
  logic signed [XW-1:0] angle_x;
  logic signed [XW-1:0] integ_x;
  logic signed [XW-1:0] tmp_x;
  logic signed [XW-1:0] ek_x;
  logic signed [XW-1:0] gyro_x;
  logic signed [XW-1:0] accel_x;

  // Floor of (x + half) / 2^s, so that halves round upwards.
  function automatic logic signed [XW-1:0] rnd_sh(input logic signed [XW-1:0] x,
                                                  input int unsigned s);
    logic signed [XW-1:0] biased;
    biased = x + (X_ONE <<< (s - 1));
    return biased >>> s;
  endfunction

  // Clamp to the signed state range.
  function automatic logic signed [STATE_WIDTH-1:0] sat_st(
    input logic signed [XW-1:0] x);
    logic signed [STATE_WIDTH-1:0] r;
    if (x > ST_MAX_X) begin
      r = ST_MAX_X[STATE_WIDTH-1:0];
    end else if (x < ST_MIN_X) begin
      r = ST_MIN_X[STATE_WIDTH-1:0];
    end else begin
      r = x[STATE_WIDTH-1:0];
    end
    return r;
  endfunction

  // Sign extension of the operands into the working width.
  assign prod_x = {{(XW - PW){prod[PW-1]}}, prod};
  assign angle_x = {{(XW - STATE_WIDTH){angle[STATE_WIDTH-1]}}, angle};
  assign integ_x = {{(XW - STATE_WIDTH){integ[STATE_WIDTH-1]}}, integ};
  assign tmp_x = {{(XW - STATE_WIDTH){tmp[STATE_WIDTH-1]}}, tmp};
  assign ek_x = {{(XW - STATE_WIDTH){ek[STATE_WIDTH-1]}}, ek};
  assign gyro_x = {{(XW - SW){gyro[SW-1]}}, gyro};
  assign accel_x = {{(XW - SW){accel[SW-1]}}, accel};

  // Weight of the accelerometer angle in the first-order blend, 1 - a.
  assign blend_rest = tacf_pkg::BLEND_UNITY - {1'b0, cfg.blend};

  // Operand selection for the multiplier; its product is ready a step later.
  always_comb begin
    mul_a = tmp;
    mul_b = {2'b00, cfg.period};
    if (!ctrl.second) begin
      unique case (ctrl.step)
        tacf_pkg::F1_MUL_GYRO: begin
          mul_a = {{(STATE_WIDTH - SW){gyro[SW-1]}}, gyro};
          mul_b = {2'b00, cfg.period};
        end
        tacf_pkg::F1_MUL_ACCEL: begin
          mul_a = {{(STATE_WIDTH - SW){accel[SW-1]}}, accel};
          mul_b = {1'b0, blend_rest};
        end
        tacf_pkg::F1_MUL_BLEND: begin
          mul_a = tmp;
          mul_b = {2'b00, cfg.blend};
        end
        default: begin
          mul_a = tmp;
          mul_b = {2'b00, cfg.period};
        end
      endcase
    end else begin
      unique case (ctrl.step)
        tacf_pkg::F2_MUL_EK: begin
          mul_a = tmp;
          mul_b = {2'b00, cfg.gain};
        end
        tacf_pkg::F2_MUL_EKK: begin
          mul_a = ek;
          mul_b = {2'b00, cfg.gain};
        end
        default: begin
          mul_a = tmp;
          mul_b = {2'b00, cfg.period};
        end
      endcase
    end
  end

  // Add, round and clamp for the current step.
  always_comb begin
    angle_next = angle;
    integ_next = integ;
    tmp_next = tmp;
    ek_next = ek;
    accum_next = accum;
    if (ctrl.run) begin
      if (!ctrl.second) begin
        unique case (ctrl.step)
          tacf_pkg::F1_MUL_ACCEL: begin
            tmp_next = sat_st(angle_x + rnd_sh(prod_x, tacf_pkg::GYRO_DT_SHIFT));
          end
          tacf_pkg::F1_MUL_BLEND: begin
            accum_next = prod_x <<< tacf_pkg::ACCEL_SHIFT;
          end
          tacf_pkg::F1_BLEND: begin
            angle_next = sat_st(rnd_sh(prod_x + accum, tacf_pkg::DT_SHIFT));
          end
          default: begin
            tmp_next = tmp;
          end
        endcase
      end else begin
        unique case (ctrl.step)
          tacf_pkg::F2_ERROR: begin
            tmp_next = sat_st((accel_x <<< tacf_pkg::ACCEL_SHIFT) - angle_x);
          end
          tacf_pkg::F2_EK: begin
            ek_next = sat_st(rnd_sh(prod_x, tacf_pkg::GAIN_SHIFT));
          end
          tacf_pkg::F2_EKK: begin
            tmp_next = sat_st(rnd_sh(prod_x, tacf_pkg::GAIN_SHIFT));
          end
          tacf_pkg::F2_INTEG: begin
            integ_next = sat_st(integ_x + rnd_sh(prod_x, tacf_pkg::DT_SHIFT));
          end
          tacf_pkg::F2_RATE_A: begin
            tmp_next = sat_st(integ_x + (ek_x <<< 1));
          end
          tacf_pkg::F2_RATE_B: begin
            tmp_next = sat_st(tmp_x + (gyro_x <<< tacf_pkg::GYRO_SHIFT));
          end
          tacf_pkg::F2_ANGLE: begin
            angle_next = sat_st(angle_x + rnd_sh(prod_x, tacf_pkg::DT_SHIFT));
          end
          default: begin
            tmp_next = tmp;
          end
        endcase
      end
    end
  end

  // Filter state, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      integ <= '0;
    end else begin
      angle <= angle_next;
      integ <= integ_next;
    end
  end

  // Working registers and the registered product.
  always_ff @(posedge clk) begin
    tmp <= tmp_next;
    ek <= ek_next;
    accum <= accum_next;
    prod <= mul_a * mul_b;
  end

endmodule

// ===== src/tacf_seq.sv =====
// ----------------------------------------------------------------------------
// tacf_seq: item sequencer
// Takes an input item, holds it for the lanes, steps both lanes through the
// selected filter and hands the finished angles to the output stage.
// ----------------------------------------------------------------------------
module tacf_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  tacf_pkg::sample_t     sample,
  input  logic                  result_valid,
  input  logic                  result_ready,
  output tacf_pkg::sample_t     held,
  output tacf_pkg::lane_ctrl_t  ctrl,
  output logic                  load
);

  tacf_pkg::seq_state_t state;
  tacf_pkg::seq_state_t state_next;
  tacf_pkg::step_t      step;
  tacf_pkg::step_t      step_next;
  tacf_pkg::step_t      last_step;

  assign last_step = held.mode ? tacf_pkg::F2_ANGLE : tacf_pkg::F1_BLEND;

  assign ctrl.run = (state == tacf_pkg::ST_RUN);
  assign ctrl.second = held.mode;
  assign ctrl.step = step;

  // State register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tacf_pkg::ST_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    step_next = step;
    sample_ready = 1'b0;
    load = 1'b0;
    unique case (state)
      tacf_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = tacf_pkg::ST_RUN;
          step_next = '0;
        end
      end
      tacf_pkg::ST_RUN: begin
        if (step == last_step) begin
          state_next = tacf_pkg::ST_FINISH;
        end else begin
          step_next = step + 4'd1;
        end
      end
      tacf_pkg::ST_FINISH: begin
        load = !result_valid || result_ready;
        if (load) begin
          state_next = tacf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tacf_pkg::ST_IDLE;
      end
    endcase
  end

  // The accepted item is held for the whole update.
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      held <= sample;
    end
  end

endmodule

// ===== src/tacf_merge.sv =====
// ----------------------------------------------------------------------------
// tacf_merge: output stage
// Rounds the two lane angles to the output format, clamps them and holds
// the result item until the receiver takes it.
// ----------------------------------------------------------------------------
module tacf_merge #(
  parameter int STATE_WIDTH = tacf_pkg::STATE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic signed [STATE_WIDTH-1:0] lane_angle_x,
  input  logic signed [STATE_WIDTH-1:0] lane_angle_y,
  output logic                          result_valid,
  input  logic                          result_ready,
  output tacf_pkg::result_t             result
);

  localparam int SW = tacf_pkg::SAMPLE_WIDTH;
  localparam int RW = STATE_WIDTH + 1;
  localparam logic signed [RW-1:0] R_HALF = RW'(1) <<< (tacf_pkg::OUT_SHIFT - 1);
  localparam logic signed [RW-1:0] R_MAX = {{(RW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [RW-1:0] R_MIN = ~R_MAX;

  logic signed [SW-1:0] out_x;
  logic signed [SW-1:0] out_y;

  // Round half up to Q9.7 and clamp to the output range.
  function automatic logic signed [SW-1:0] to_out(
    input logic signed [STATE_WIDTH-1:0] a);
    logic signed [RW-1:0] r;
    logic signed [SW-1:0] o;
    r = ($signed({a[STATE_WIDTH-1], a}) + R_HALF) >>> tacf_pkg::OUT_SHIFT;
    if (r > R_MAX) begin
      o = R_MAX[SW-1:0];
    end else if (r < R_MIN) begin
      o = R_MIN[SW-1:0];
    end else begin
      o = r[SW-1:0];
    end
    return o;
  endfunction

  assign out_x = to_out(lane_angle_x);
  assign out_y = to_out(lane_angle_y);

  // Output handshake flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Output item register.
  always_ff @(posedge clk) begin
    if (load) begin
      result.angle_x <= out_x;
      result.angle_y <= out_y;
    end
  end

endmodule

// ===== src/two_axis_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// two_axis_complementary_filter: fused tilt angles for two axes
// Each input item carries gyro rates and accelerometer angles for x and y;
// each result item carries the fused angle of both axes.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the sample channel (valid/ready) and leave on the result
// channel (valid/ready), one result for every input item. Registers are
// written on the cfg channel, which is always ready; indexes above the
// register list are ignored. Write them only while the block is idle.
// An x lane and a y lane run side by side, each with one multiplier, and
// the item is taken in only while both lanes are idle. A first-order item
// takes four lane steps, a second-order item eleven; the chain of dependent
// multiplications through each lane's multiplier sets this. The result is
// loaded from the finish state after the last lane step, and the next item
// is accepted only once the sequencer is back in idle, so the block does
// not take a new item before the last one has reached the output register.
// The result is held in an output register: the block accepts a new item
// while a result waits, and stops before its own result stage if the
// receiver has not taken the previous one. Reset clears the angles, the
// rate integrators and the handshakes and restores the register defaults.
// ----------------------------------------------------------------------------
module two_axis_complementary_filter #(
  parameter int STATE_WIDTH = tacf_pkg::STATE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  tacf_pkg::sample_t                      sample,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output tacf_pkg::result_t                      result,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tacf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [tacf_pkg::COEF_WIDTH-1:0]        cfg_data
);

  tacf_pkg::cfg_t       cfg;
  tacf_pkg::sample_t    held;
  tacf_pkg::lane_ctrl_t ctrl;
  logic                 load;

  logic signed [STATE_WIDTH-1:0] lane_angle_x;
  logic signed [STATE_WIDTH-1:0] lane_angle_y;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend <= tacf_pkg::BLEND_RESET;
      cfg.period <= tacf_pkg::PERIOD_RESET;
      cfg.gain <= tacf_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tacf_pkg::CFG_BLEND:  cfg.blend <= cfg_data;
        tacf_pkg::CFG_PERIOD: cfg.period <= cfg_data;
        tacf_pkg::CFG_GAIN:   cfg.gain <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // Sequencer for the item.
  tacf_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .held         (held),
    .ctrl         (ctrl),
    .load         (load)
  );

  // One lane per axis.
  tacf_lane #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .cfg   (cfg),
    .gyro  (held.gyro_rate_x),
    .accel (held.accel_angle_x),
    .angle (lane_angle_x)
  );

  tacf_lane #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .cfg   (cfg),
    .gyro  (held.gyro_rate_y),
    .accel (held.accel_angle_y),
    .angle (lane_angle_y)
  );

  // Output stage combining both lanes.
  tacf_merge #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .lane_angle_x (lane_angle_x),
    .lane_angle_y (lane_angle_y),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
